// ===== hdl/rar_pkg.sv =====
// ----------------------------------------------------------------------------
// rar_pkg - shared types and constants for rational arithmetic with reduction
// Operand and product widths, action codes, payload structs, divider status.
// ----------------------------------------------------------------------------
package rar_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int PROD_W        = 2 * OPERAND_WIDTH;  // one cross product
    localparam int NUM_W         = PROD_W + 1;         // sum of two products
    localparam int MAG_W         = PROD_W;             // magnitudes fed to gcd

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_SUB = 2'd1;
    localparam logic [1:0] ACT_MUL = 2'd2;
    localparam logic [1:0] ACT_DIV = 2'd3;

    typedef struct packed {
        logic [1:0]                      action;
        logic signed [OPERAND_WIDTH-1:0] first_num;
        logic signed [OPERAND_WIDTH-1:0] first_den;
        logic signed [OPERAND_WIDTH-1:0] second_num;
        logic signed [OPERAND_WIDTH-1:0] second_den;
    } rar_req_t;

    typedef struct packed {
        logic signed [NUM_W-1:0]  result_num;
        logic signed [PROD_W-1:0] result_den;
        logic                     zero_error;
    } rar_rsp_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rar_div_stat_t;

endpackage

// ===== hdl/rar_div.sv =====
// ----------------------------------------------------------------------------
// rar_div - restoring unsigned divider, one quotient bit per cycle
// Used for the gcd remainder steps and the two final reductions.
// ----------------------------------------------------------------------------
module rar_div #(
    parameter int WIDTH = rar_pkg::MAG_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [WIDTH-1:0]      dividend,
    input  logic [WIDTH-1:0]      divisor,   // held stable while busy
    output logic [WIDTH-1:0]      quotient,
    output logic [WIDTH-1:0]      remainder,
    output rar_pkg::rar_div_stat_t stat
);

    localparam int CW = $clog2(WIDTH + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] rem_reg;

    logic [WIDTH:0] trial;
    logic [WIDTH:0] diff;
    logic           fits;

    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = ~diff[WIDTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[WIDTH-2:0], fits};
            rem_reg <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hdl/rational_arith_reduce_top.sv =====
// ----------------------------------------------------------------------------
// rational_arith_reduce_top - fraction add/sub/mul/div with gcd reduction
// Sequencer around one multiplier and one shared bit-serial divider.
// ----------------------------------------------------------------------------
// Sequence: from request transfer to result valid the block runs the multiply
//   states S_MUL0 to S_MUL2, sum, load, one divider pass per gcd step, final
//   test, zero check, the two reductions, output. Both terms zero: no gcd
//   step and no reduction is run.
// Throughput: one item at a time; the request side stalls until the result
//   is loaded into the output register.
// Reset: rst_n asynchronous, active low; sequencer idle, no result pending.
// ----------------------------------------------------------------------------
module rational_arith_reduce_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  rar_pkg::rar_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rar_pkg::rar_rsp_t rsp
);

    localparam int W  = rar_pkg::OPERAND_WIDTH;
    localparam int PW = rar_pkg::PROD_W;
    localparam int NW = rar_pkg::NUM_W;
    localparam int MW = rar_pkg::MAG_W;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL0  = 4'd1;   // n1*d2 (n1*n2 for multiply)
    localparam logic [3:0] S_MUL1  = 4'd2;   // d1*n2
    localparam logic [3:0] S_MUL2  = 4'd3;   // d1*d2 (d1*n2 for divide)
    localparam logic [3:0] S_SUM   = 4'd4;   // combine products
    localparam logic [3:0] S_MAG   = 4'd5;   // load gcd operands
    localparam logic [3:0] S_GCD   = 4'd6;   // test y, launch x % y
    localparam logic [3:0] S_GWAIT = 4'd7;
    localparam logic [3:0] S_CHK   = 4'd8;   // gcd in x; zero check
    localparam logic [3:0] S_NWAIT = 4'd9;   // |num| / g
    localparam logic [3:0] S_DWAIT = 4'd10;  // |den| / g
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] state_reg;

    logic [1:0]          act_reg;
    logic signed [W-1:0] n1_reg, d1_reg, n2_reg, d2_reg;
    logic signed [PW-1:0] pa_reg, pb_reg, den_reg;
    logic signed [NW-1:0] num_reg;
    logic [MW-1:0]        x_reg, y_reg, qn_reg;
    logic                 err_reg;
    logic signed [NW-1:0] res_num_reg;
    logic signed [PW-1:0] res_den_reg;

    rar_pkg::rar_rsp_t rsp_reg;
    logic              rsp_valid_reg;

    // shared multiplier
    logic signed [W-1:0]  mul_a, mul_b;
    logic signed [PW-1:0] product;

    always_comb
    begin
        case (state_reg)
            S_MUL0:
            begin
                mul_a = n1_reg;
                mul_b = (act_reg == rar_pkg::ACT_MUL) ? n2_reg : d2_reg;
            end
            S_MUL1:
            begin
                mul_a = d1_reg;
                mul_b = n2_reg;
            end
            default:
            begin
                mul_a = d1_reg;
                mul_b = (act_reg == rar_pkg::ACT_DIV) ? n2_reg : d2_reg;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // magnitudes of the unreduced pair
    logic [MW-1:0] mag_num, mag_den;
    logic signed [NW-1:0] neg_num;
    logic signed [PW-1:0] neg_den;

    assign neg_num = -num_reg;
    assign neg_den = -den_reg;
    assign mag_num = num_reg[NW-1] ? neg_num[MW-1:0] : num_reg[MW-1:0];
    assign mag_den = den_reg[PW-1] ? MW'(neg_den) : MW'(den_reg);

    // shared divider
    logic                   div_start;
    logic [MW-1:0]          div_dividend, div_divisor, div_quo, div_rem;
    rar_pkg::rar_div_stat_t div_stat;

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = x_reg;
        case (state_reg)
            S_GCD:
            begin
                div_start    = (y_reg != '0);
                div_dividend = x_reg;
            end
            S_CHK:
            begin
                div_start    = (x_reg != '0);
                div_dividend = mag_num;
            end
            S_NWAIT:
            begin
                div_start    = div_stat.done;
                div_dividend = mag_den;
            end
            default:
            begin
                div_start    = 1'b0;
                div_dividend = x_reg;
            end
        endcase
    end

    // gcd steps divide by y; the reductions divide by the gcd held in x
    assign div_divisor = (state_reg == S_GCD || state_reg == S_GWAIT) ? y_reg : x_reg;

    rar_div #(
        .WIDTH (MW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .stat      (div_stat)
    );

    // signed quotients for the final result
    logic [NW-1:0] qn_ext;
    logic [PW-1:0] qd_ext;
    assign qn_ext = NW'(qn_reg);
    assign qd_ext = PW'(div_quo);

    logic out_free;
    assign out_free = ~rsp_valid_reg | ~rsp_stall;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:  if (req_valid) state_reg <= S_MUL0;
                S_MUL0:  state_reg <= S_MUL1;
                S_MUL1:  state_reg <= S_MUL2;
                S_MUL2:  state_reg <= S_SUM;
                S_SUM:   state_reg <= S_MAG;
                S_MAG:   state_reg <= S_GCD;
                S_GCD:   state_reg <= (y_reg != '0) ? S_GWAIT : S_CHK;
                S_GWAIT: if (div_stat.done) state_reg <= S_GCD;
                S_CHK:   state_reg <= (x_reg != '0) ? S_NWAIT : S_OUT;
                S_NWAIT: if (div_stat.done) state_reg <= S_DWAIT;
                S_DWAIT: if (div_stat.done) state_reg <= S_OUT;
                S_OUT:   if (out_free) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                act_reg <= req.action;
                n1_reg  <= req.first_num;
                d1_reg  <= req.first_den;
                n2_reg  <= req.second_num;
                d2_reg  <= req.second_den;
            end
            S_MUL0: pa_reg  <= product;
            S_MUL1: pb_reg  <= product;
            S_MUL2: den_reg <= product;
            S_SUM:
            begin
                case (act_reg)
                    rar_pkg::ACT_ADD: num_reg <= NW'(pa_reg) + NW'(pb_reg);
                    rar_pkg::ACT_SUB: num_reg <= NW'(pa_reg) - NW'(pb_reg);
                    default:          num_reg <= NW'(pa_reg);
                endcase
            end
            S_MAG:
            begin
                x_reg <= mag_num;
                y_reg <= mag_den;
            end
            S_GWAIT:
            begin
                if (div_stat.done)
                begin
                    x_reg <= y_reg;
                    y_reg <= div_rem;
                end
            end
            S_CHK:
            begin
                // both zero: report 0/0 without reduction
                err_reg     <= (x_reg == '0);
                res_num_reg <= '0;
                res_den_reg <= '0;
            end
            S_NWAIT:
            begin
                if (div_stat.done)
                    qn_reg <= div_quo;
            end
            S_DWAIT:
            begin
                if (div_stat.done)
                begin
                    res_num_reg <= num_reg[NW-1] ? -qn_ext : qn_ext;
                    res_den_reg <= den_reg[PW-1] ? -qd_ext : qd_ext;
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (state_reg == S_OUT && out_free)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            rsp_reg.result_num <= res_num_reg;
            rsp_reg.result_den <= res_den_reg;
            rsp_reg.zero_error <= err_reg;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // divider is only launched when free
    a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider launched while busy");

    // no division in flight while idle
    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !div_stat.busy)
        else $error("divider busy in idle");

    // reductions only run with a nonzero gcd
    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NWAIT || state_reg == S_DWAIT) |-> x_reg != '0)
        else $error("reduction by zero gcd");

    // a gcd step always ends back at the loop test
    a_gwait_return: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GWAIT && div_stat.done) |=> state_reg == S_GCD)
        else $error("gcd step did not return");

endmodule

// ===== bench/rational_arith_reduce_top_test.sv =====
// ----------------------------------------------------------------------------
// rational_arith_reduce_top_test - self-checking bench for fraction arithmetic
// Drives fraction pairs with all four actions, first from a directed table,
// then at random, with random idling on both sides. Every result transfer is
// checked field by field against a hand-worked result or a gcd predictor.
// ----------------------------------------------------------------------------
module rational_arith_reduce_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_RANDOM    = 830;
    localparam int  CYCLE_LIMIT = 8_000_000;   // watchdog bound on the whole run
    localparam int  SETTLE      = 2000;        // idle time after the last result

    // One row of the directed table. Where "known" is set the result is
    // typed in by hand, otherwise the predictor supplies it.
    typedef struct {
        rar_pkg::rar_req_t stim;
        bit                known;
        rar_pkg::rar_rsp_t want;
    } row_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    rar_pkg::rar_req_t req       = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    rar_pkg::rar_rsp_t rsp;

    rar_pkg::rar_rsp_t pending_fractions[$];   // results still owed by the block
    row_t              directed[$];
    int                mismatches = 0;
    int                cycles     = 0;
    bit                quiet      = 1'b0;      // no idling on either side while set

    rational_arith_reduce_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    // Cross products, then division of both terms by the Euclidean gcd of
    // their magnitudes. Signs are left as they fall; 0/0 is flagged.
    function automatic rar_pkg::rar_rsp_t reduced_fraction(rar_pkg::rar_req_t r);
        longint            n1, d1, n2, d2, num, den;
        longint unsigned   x, y, t;
        rar_pkg::rar_rsp_t o;
        n1 = r.first_num;
        d1 = r.first_den;
        n2 = r.second_num;
        d2 = r.second_den;
        case (r.action)
            rar_pkg::ACT_ADD: begin num = n1 * d2 + d1 * n2; den = d1 * d2; end
            rar_pkg::ACT_SUB: begin num = n1 * d2 - d1 * n2; den = d1 * d2; end
            rar_pkg::ACT_MUL: begin num = n1 * n2;           den = d1 * d2; end
            default:          begin num = n1 * d2;           den = d1 * n2; end
        endcase
        x = (num < 0) ? -num : num;
        y = (den < 0) ? -den : den;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        o = '0;
        if (x == 0)
        begin
            o.zero_error = 1'b1;
        end
        else
        begin
            num          = num / longint'(x);
            den          = den / longint'(x);
            o.result_num = num[rar_pkg::NUM_W-1:0];
            o.result_den = den[rar_pkg::PROD_W-1:0];
        end
        return o;
    endfunction

    function automatic rar_pkg::rar_req_t pack_req(logic [1:0] a, int n1, int d1,
                                                   int n2, int d2);
        rar_pkg::rar_req_t r;
        r.action     = a;
        r.first_num  = n1[rar_pkg::OPERAND_WIDTH-1:0];
        r.first_den  = d1[rar_pkg::OPERAND_WIDTH-1:0];
        r.second_num = n2[rar_pkg::OPERAND_WIDTH-1:0];
        r.second_den = d2[rar_pkg::OPERAND_WIDTH-1:0];
        return r;
    endfunction

    task automatic add_row(logic [1:0] a, int n1, int d1, int n2, int d2,
                           bit known = 1'b0, longint rn = 0, longint rd = 0, bit err = 0);
        row_t w;
        w.stim            = pack_req(a, n1, d1, n2, d2);
        w.known           = known;
        w.want.result_num = rn[rar_pkg::NUM_W-1:0];
        w.want.result_den = rd[rar_pkg::PROD_W-1:0];
        w.want.zero_error = err;
        directed.push_back(w);
    endtask

    // Random operand: half from the full range, three in ten small magnitudes
    // in -32..32, otherwise zero or an extreme.
    function automatic int rand_operand();
        case ($urandom_range(9))
            0:       return 0;
            1:       return ($urandom_range(1)) ? 32767 : -32768;
            2, 3, 4: return int'($urandom_range(64)) - 32;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    // One request transfer: optional idle cycles first, then hold the
    // payload until the block stops stalling.
    task automatic send(rar_pkg::rar_req_t r, rar_pkg::rar_rsp_t want);
        while (!quiet && $urandom_range(99) < 21)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall);
        pending_fractions.push_back(want);
    endtask

    // Result side: check each transfer, then choose the next stall level.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_fractions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d/%0d err %0b",
                             rsp.result_num, rsp.result_den, rsp.zero_error);
            end
            else
            begin
                rar_pkg::rar_rsp_t w;
                w = pending_fractions.pop_front();
                if (rsp.result_num !== w.result_num || rsp.result_den !== w.result_den
                    || rsp.zero_error !== w.zero_error)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d err %0b, got %0d/%0d err %0b",
                                 w.result_num, w.result_den, w.zero_error,
                                 rsp.result_num, rsp.result_den, rsp.zero_error);
                end
            end
        end
        rsp_stall <= !quiet && ($urandom_range(99) < 21);
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        rar_pkg::rar_req_t r;
        // Directed: hand-worked results for the special cases and extremes.
        add_row(rar_pkg::ACT_ADD, 0, 0, 0, 0, 1, 0, 0, 1);      // both terms zero
        add_row(rar_pkg::ACT_MUL, 0, 5, 3, 7, 1, 0, 1, 0);      // zero numerator
        add_row(rar_pkg::ACT_MUL, 0, -5, 3, 7, 1, 0, -1, 0);    // keeps den sign
        add_row(rar_pkg::ACT_DIV, 3, 4, 0, 5, 1, 1, 0, 0);      // zero denominator
        add_row(rar_pkg::ACT_DIV, -3, 4, 0, 5, 1, -1, 0, 0);
        add_row(rar_pkg::ACT_ADD, 1, 0, 1, 0, 1, 0, 0, 1);      // both zero via cross terms
        add_row(rar_pkg::ACT_MUL, -32768, -32768, -32768, -32768, 1, 1, 1, 0);
        add_row(rar_pkg::ACT_ADD, -32768, 1, -32768, 1, 1, -65536, 1, 0);
        add_row(rar_pkg::ACT_SUB, 32767, 1, -32768, 1, 1, 65535, 1, 0);
        add_row(rar_pkg::ACT_ADD, -32768, -1, -32768, -1, 1, 65536, 1, 0);
        add_row(rar_pkg::ACT_ADD, -32768, -32768, -32768, -32768);
        add_row(rar_pkg::ACT_SUB, 32767, -32768, -32768, 32767);
        add_row(rar_pkg::ACT_MUL, 32767, 32767, 32767, -32768);
        add_row(rar_pkg::ACT_DIV, -32768, 32767, -32768, -1);
        add_row(rar_pkg::ACT_ADD, 1, 2, 1, 3);
        add_row(rar_pkg::ACT_SUB, 1, 2, 1, 2);
        add_row(rar_pkg::ACT_SUB, 5, 6, -7, 10);
        add_row(rar_pkg::ACT_MUL, 6, -35, 14, 15);
        add_row(rar_pkg::ACT_DIV, 12, 25, -18, 35);
        add_row(rar_pkg::ACT_DIV, 32767, 1, 1, 32767);
        add_row(rar_pkg::ACT_ADD, -1, -1, -1, -1);
        add_row(rar_pkg::ACT_MUL, 255, 256, 256, 255);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send(directed[i].stim,
                 directed[i].known ? directed[i].want : reduced_fraction(directed[i].stim));

        for (int i = 0; i < N_RANDOM; i++)
        begin
            quiet = (i >= 300 && i < 420);
            if (i == 500)
            begin
                // drain: hold off until the block has nothing owed
                req_valid <= 1'b0;
                while (pending_fractions.size() != 0)
                    @(posedge clk);
            end
            r = pack_req(2'($urandom_range(3)), rand_operand(), rand_operand(),
                         rand_operand(), rand_operand());
            send(r, reduced_fraction(r));
        end
        req_valid <= 1'b0;

        while (pending_fractions.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (mismatches == 0 && pending_fractions.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/rar_pkg.sv
hdl/rar_div.sv
hdl/rational_arith_reduce_top.sv
bench/rational_arith_reduce_top_test.sv
